// ===== rtl/mbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsp_pkg
// shared types, message kind codes and byte constants of the midi parser
// ----------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

  // defaults for the top level parameters
  localparam int unsigned PORT_COUNT_DEF      = 2;
  localparam int unsigned CLOCKS_PER_BEAT_DEF = 24;

  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // beat counter value at which the led goes off
  localparam int unsigned LED_OFF_COUNT = 5;

  // message kind codes
  localparam logic [4:0] KIND_NONE    = 5'd0;
  localparam logic [4:0] KIND_SYSEX   = 5'd8;
  localparam logic [4:0] KIND_QFRAME  = 5'd9;
  localparam logic [4:0] KIND_SONGPTR = 5'd10;
  localparam logic [4:0] KIND_SONGSEL = 5'd11;
  localparam logic [4:0] KIND_F9      = 5'd12;
  localparam logic [4:0] KIND_F6      = 5'd13;
  localparam logic [4:0] KIND_F7      = 5'd14;
  localparam logic [4:0] KIND_CLOCK   = 5'd15;
  localparam logic [4:0] KIND_START   = 5'd16;
  localparam logic [4:0] KIND_CONT    = 5'd17;
  localparam logic [4:0] KIND_STOP    = 5'd18;
  localparam logic [4:0] KIND_SENSE   = 5'd19;
  localparam logic [4:0] KIND_RESET   = 5'd20;

  // status high nibbles
  localparam logic [3:0] HI_PROG    = 4'hC;
  localparam logic [3:0] HI_CHAN_AT = 4'hD;
  localparam logic [3:0] HI_SYSTEM  = 4'hF;

  // system status bytes
  localparam logic [7:0] BYTE_SYSEX   = 8'hF0;
  localparam logic [7:0] BYTE_QFRAME  = 8'hF1;
  localparam logic [7:0] BYTE_SONGPTR = 8'hF2;
  localparam logic [7:0] BYTE_SONGSEL = 8'hF3;
  localparam logic [7:0] BYTE_F6      = 8'hF6;
  localparam logic [7:0] BYTE_F7      = 8'hF7;
  localparam logic [7:0] BYTE_CLOCK   = 8'hF8;
  localparam logic [7:0] BYTE_F9      = 8'hF9;
  localparam logic [7:0] BYTE_START   = 8'hFA;
  localparam logic [7:0] BYTE_CONT    = 8'hFB;
  localparam logic [7:0] BYTE_STOP    = 8'hFC;
  localparam logic [7:0] BYTE_SENSE   = 8'hFE;
  localparam logic [7:0] BYTE_RESET   = 8'hFF;

  // message lengths in bytes, status included
  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_LONG  = 2'd3;

  typedef enum logic [1:0] {
    CLS_IGNORE   = 2'd0,
    CLS_OPEN     = 2'd1,
    CLS_REALTIME = 2'd2,
    CLS_DATA     = 2'd3
  } cls_e;

  // one classified byte
  typedef struct packed {
    cls_e       cls;
    logic [4:0] kind;
    logic [3:0] chan;
    logic [1:0] exp_len;
    logic [6:0] data;
    logic       is_clock;
    logic       is_start;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/mbsp_front.sv =====
// ----------------------------------------------------------------------------
// mbsp_front
// classifies one received byte into status, data, realtime or ignored
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_front #(
  parameter int unsigned PORT_COUNT = mbsp_pkg::PORT_COUNT_DEF,
  parameter int unsigned PortW      = 1
) (
  input  wire logic [PortW-1:0] port_i,
  input  wire logic [7:0]       rx_byte_i,
  output mbsp_pkg::item_t       item_o
);

  logic       in_range;
  logic [3:0] hi;

  assign in_range = ({1'b0, port_i} < (PortW + 1)'(PORT_COUNT));
  assign hi       = rx_byte_i[7:4];

  always_comb begin
    item_o      = '0;
    item_o.cls  = mbsp_pkg::CLS_IGNORE;
    item_o.data = rx_byte_i[6:0];
    if (in_range) begin
      if (!rx_byte_i[7]) begin
        item_o.cls = mbsp_pkg::CLS_DATA;
      end else if (hi != mbsp_pkg::HI_SYSTEM) begin
        // channel status, kind 1 for 8n up to 7 for En
        item_o.cls     = mbsp_pkg::CLS_OPEN;
        item_o.kind    = {2'b00, rx_byte_i[6:4]} + 5'd1;
        item_o.chan    = rx_byte_i[3:0];
        item_o.exp_len = (hi == mbsp_pkg::HI_PROG || hi == mbsp_pkg::HI_CHAN_AT) ?
                         mbsp_pkg::LEN_SHORT : mbsp_pkg::LEN_LONG;
      end else begin
        unique case (rx_byte_i)
          mbsp_pkg::BYTE_SYSEX: begin
            item_o.cls     = mbsp_pkg::CLS_OPEN;
            item_o.kind    = mbsp_pkg::KIND_SYSEX;
            item_o.exp_len = mbsp_pkg::LEN_LONG;
          end
          mbsp_pkg::BYTE_SONGPTR: begin
            item_o.cls     = mbsp_pkg::CLS_OPEN;
            item_o.kind    = mbsp_pkg::KIND_SONGPTR;
            item_o.exp_len = mbsp_pkg::LEN_LONG;
          end
          mbsp_pkg::BYTE_QFRAME: begin
            item_o.cls     = mbsp_pkg::CLS_OPEN;
            item_o.kind    = mbsp_pkg::KIND_QFRAME;
            item_o.exp_len = mbsp_pkg::LEN_SHORT;
          end
          mbsp_pkg::BYTE_SONGSEL: begin
            item_o.cls     = mbsp_pkg::CLS_OPEN;
            item_o.kind    = mbsp_pkg::KIND_SONGSEL;
            item_o.exp_len = mbsp_pkg::LEN_SHORT;
          end
          mbsp_pkg::BYTE_F9: begin
            item_o.cls     = mbsp_pkg::CLS_OPEN;
            item_o.kind    = mbsp_pkg::KIND_F9;
            item_o.exp_len = mbsp_pkg::LEN_SHORT;
          end
          mbsp_pkg::BYTE_F6: begin
            item_o.cls  = mbsp_pkg::CLS_REALTIME;
            item_o.kind = mbsp_pkg::KIND_F6;
          end
          mbsp_pkg::BYTE_F7: begin
            item_o.cls  = mbsp_pkg::CLS_REALTIME;
            item_o.kind = mbsp_pkg::KIND_F7;
          end
          mbsp_pkg::BYTE_CLOCK: begin
            item_o.cls      = mbsp_pkg::CLS_REALTIME;
            item_o.kind     = mbsp_pkg::KIND_CLOCK;
            item_o.is_clock = 1'b1;
          end
          mbsp_pkg::BYTE_START: begin
            item_o.cls      = mbsp_pkg::CLS_REALTIME;
            item_o.kind     = mbsp_pkg::KIND_START;
            item_o.is_start = 1'b1;
          end
          mbsp_pkg::BYTE_CONT: begin
            item_o.cls  = mbsp_pkg::CLS_REALTIME;
            item_o.kind = mbsp_pkg::KIND_CONT;
          end
          mbsp_pkg::BYTE_STOP: begin
            item_o.cls  = mbsp_pkg::CLS_REALTIME;
            item_o.kind = mbsp_pkg::KIND_STOP;
          end
          mbsp_pkg::BYTE_SENSE: begin
            item_o.cls  = mbsp_pkg::CLS_REALTIME;
            item_o.kind = mbsp_pkg::KIND_SENSE;
          end
          mbsp_pkg::BYTE_RESET: begin
            item_o.cls  = mbsp_pkg::CLS_REALTIME;
            item_o.kind = mbsp_pkg::KIND_RESET;
          end
          default: begin
            // undefined system status
            item_o.cls = mbsp_pkg::CLS_IGNORE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbsp_fifo.sv =====
// ----------------------------------------------------------------------------
// mbsp_fifo
// small flop based request queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = mbsp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [Width-1:0] in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [Width-1:0] out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != CntW'(Depth));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbsp_back.sv =====
// ----------------------------------------------------------------------------
// mbsp_back
// per port message assembly, beat counter and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_back #(
  parameter int unsigned PORT_COUNT      = mbsp_pkg::PORT_COUNT_DEF,
  parameter int unsigned PortW           = 1,
  parameter int unsigned CLOCKS_PER_BEAT = mbsp_pkg::CLOCKS_PER_BEAT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  output      logic             item_ready_o,
  input  wire logic [PortW-1:0] item_port_i,
  input  wire mbsp_pkg::item_t  item_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic             msg_valid_o,
  output      logic [4:0]       msg_kind_o,
  output      logic [PortW-1:0] msg_port_o,
  output      logic [3:0]       channel_o,
  output      logic [6:0]       first_data_o,
  output      logic [6:0]       second_data_o,
  output      logic             beat_led_o
);

  localparam int unsigned CntW = $clog2(CLOCKS_PER_BEAT);

  // per port message state, kind zero means nothing pending
  logic [4:0] kind_q  [PORT_COUNT];
  logic [4:0] kind_d  [PORT_COUNT];
  logic [3:0] chan_q  [PORT_COUNT];
  logic [3:0] chan_d  [PORT_COUNT];
  logic [6:0] first_q [PORT_COUNT];
  logic [6:0] first_d [PORT_COUNT];
  logic [1:0] seen_q  [PORT_COUNT];
  logic [1:0] seen_d  [PORT_COUNT];
  logic [1:0] exp_q   [PORT_COUNT];
  logic [1:0] exp_d   [PORT_COUNT];

  logic [CntW-1:0] cc_q, cc_d;
  logic            led_q, led_d;
  logic            out_valid_q;
  logic            pop;
  logic [1:0]      seen_n;

  logic             res_valid;
  logic [4:0]       res_kind;
  logic [3:0]       res_chan;
  logic [6:0]       res_d1, res_d2;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign seen_n       = seen_q[item_port_i] + 2'd1;

  always_comb begin
    kind_d    = kind_q;
    chan_d    = chan_q;
    first_d   = first_q;
    seen_d    = seen_q;
    exp_d     = exp_q;
    cc_d      = cc_q;
    led_d     = led_q;
    res_valid = 1'b0;
    res_kind  = mbsp_pkg::KIND_NONE;
    res_chan  = '0;
    res_d1    = '0;
    res_d2    = '0;
    if (pop) begin
      unique case (item_i.cls)
        mbsp_pkg::CLS_OPEN: begin
          // a new status replaces whatever was in progress
          kind_d[item_port_i] = item_i.kind;
          chan_d[item_port_i] = item_i.chan;
          exp_d[item_port_i]  = item_i.exp_len;
          seen_d[item_port_i] = 2'd1;
        end
        mbsp_pkg::CLS_REALTIME: begin
          res_valid = 1'b1;
          res_kind  = item_i.kind;
          if (item_i.is_clock) begin
            if (cc_q == '0) begin
              led_d = 1'b1;
            end else if (cc_q == CntW'(mbsp_pkg::LED_OFF_COUNT)) begin
              led_d = 1'b0;
            end
            cc_d = (cc_q == CntW'(CLOCKS_PER_BEAT - 1)) ? '0 : cc_q + 1'b1;
          end else if (item_i.is_start) begin
            cc_d = '0;
          end
        end
        mbsp_pkg::CLS_DATA: begin
          if (seen_q[item_port_i] != 2'd0) begin
            if (seen_n >= exp_q[item_port_i]) begin
              res_valid = 1'b1;
              res_kind  = kind_q[item_port_i];
              res_chan  = chan_q[item_port_i];
              res_d1    = (seen_n == 2'd2) ? item_i.data : first_q[item_port_i];
              res_d2    = (seen_n == 2'd3) ? item_i.data : 7'd0;
              kind_d[item_port_i]  = mbsp_pkg::KIND_NONE;
              chan_d[item_port_i]  = '0;
              first_d[item_port_i] = '0;
              seen_d[item_port_i]  = '0;
              exp_d[item_port_i]   = '0;
            end else begin
              seen_d[item_port_i]  = seen_n;
              first_d[item_port_i] = item_i.data;
            end
          end
        end
        mbsp_pkg::CLS_IGNORE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(PORT_COUNT); i++) begin
        kind_q[i]  <= mbsp_pkg::KIND_NONE;
        chan_q[i]  <= '0;
        first_q[i] <= '0;
        seen_q[i]  <= '0;
        exp_q[i]   <= '0;
      end
      cc_q        <= '0;
      led_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      kind_q  <= kind_d;
      chan_q  <= chan_d;
      first_q <= first_d;
      seen_q  <= seen_d;
      exp_q   <= exp_d;
      cc_q    <= cc_d;
      led_q   <= led_d;
      if (item_ready_o) begin
        out_valid_q <= pop;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      msg_valid_o   <= res_valid;
      msg_kind_o    <= res_kind;
      msg_port_o    <= res_valid ? item_port_i : '0;
      channel_o     <= res_chan;
      first_data_o  <= res_d1;
      second_data_o <= res_d2;
      beat_led_o    <= led_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/midi_byte_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_core
// midi byte parser for several receive ports with a shared beat indicator
// ----------------------------------------------------------------------------
// path: an accepted request goes through the queue, then the result register in the back
// throughput: one byte per clock unless the result side stalls, one port update per byte
// a two entry queue keeps input accepting while a result waits downstream
// reset: all ports drop any message in progress, beat counter zero, internal led on
`default_nettype none

module midi_byte_stream_parser_core #(
  parameter int unsigned PORT_COUNT      = mbsp_pkg::PORT_COUNT_DEF,
  parameter int unsigned CLOCKS_PER_BEAT = mbsp_pkg::CLOCKS_PER_BEAT_DEF,
  parameter int unsigned PortW           = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // byte input channel
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [PortW-1:0] port_i,
  input  wire logic [7:0]       rx_byte_i,
  // result channel, one result per byte
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic             msg_valid_o,
  output      logic [4:0]       msg_kind_o,
  output      logic [PortW-1:0] msg_port_o,
  output      logic [3:0]       channel_o,
  output      logic [6:0]       first_data_o,
  output      logic [6:0]       second_data_o,
  output      logic             beat_led_o
);

  localparam int unsigned ItemW = $bits(mbsp_pkg::item_t);
  localparam int unsigned QW    = PortW + ItemW;

  mbsp_pkg::item_t  front_item;
  logic [QW-1:0]    q_in, q_out;
  logic             q_valid, q_ready;
  logic [PortW-1:0] back_port;
  mbsp_pkg::item_t  back_item;

  // front: classify the incoming byte, no state involved
  mbsp_front #(
    .PORT_COUNT (PORT_COUNT),
    .PortW      (PortW)
  ) u_front (
    .port_i    (port_i),
    .rx_byte_i (rx_byte_i),
    .item_o    (front_item)
  );

  // queue carries the port tag next to the classified request
  assign q_in = {port_i, front_item};

  mbsp_fifo #(
    .Width (QW),
    .Depth (mbsp_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (q_in),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_out)
  );

  assign back_port = q_out[QW-1:ItemW];
  assign back_item = mbsp_pkg::item_t'(q_out[ItemW-1:0]);

  // back: per port assembly, beat counter, registered result
  mbsp_back #(
    .PORT_COUNT      (PORT_COUNT),
    .PortW           (PortW),
    .CLOCKS_PER_BEAT (CLOCKS_PER_BEAT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_ready_o  (q_ready),
    .item_port_i   (back_port),
    .item_i        (back_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .msg_valid_o   (msg_valid_o),
    .msg_kind_o    (msg_kind_o),
    .msg_port_o    (msg_port_o),
    .channel_o     (channel_o),
    .first_data_o  (first_data_o),
    .second_data_o (second_data_o),
    .beat_led_o    (beat_led_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_midi_byte_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_midi_byte_stream_parser_core
// feeds tagged midi bytes through the parser and checks every result in order
// against a cycle-free model of the per-port message state and the beat led
// ----------------------------------------------------------------------------

module tb_midi_byte_stream_parser_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PORT_N   = mbsp_pkg::PORT_COUNT_DEF;
  localparam int unsigned BEAT_LEN = mbsp_pkg::CLOCKS_PER_BEAT_DEF;
  localparam int unsigned PW       = (PORT_N > 1) ? $clog2(PORT_N) : 1;

  // status bytes with no meaning, the parser must swallow them
  localparam logic [7:0] BYTE_UNDEF_F4 = 8'hF4;
  localparam logic [7:0] BYTE_UNDEF_F5 = 8'hF5;
  localparam logic [7:0] BYTE_UNDEF_FD = 8'hFD;

  localparam int unsigned RANDOM_BYTES = 950;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned REPORT_CAP   = 60;

  // one result as seen on the output channel
  typedef struct packed {
    logic          msg_valid;
    logic [4:0]    kind;
    logic [PW-1:0] port;
    logic [3:0]    chan;
    logic [6:0]    first;
    logic [6:0]    second;
    logic          led;
  } msg_t;

  // --------------------------------------------------------------------------
  // message book: tracks per-port parse state and the beat counter, keeps the
  // results owed by the block in request order
  // --------------------------------------------------------------------------
  class midi_msg_book;
    logic [7:0]  status_held [PORT_N];
    logic [6:0]  first_held  [PORT_N];
    logic [6:0]  second_held [PORT_N];
    logic [1:0]  seen        [PORT_N];
    logic [1:0]  expected    [PORT_N];
    int unsigned beat_count;
    logic        led;
    msg_t        msgs_due [$];
    int unsigned errors;

    function new();
      for (int p = 0; p < PORT_N; p++) begin
        status_held[p] = '0;
        first_held[p]  = '0;
        second_held[p] = '0;
        seen[p]        = '0;
        expected[p]    = '0;
      end
      beat_count = 0;
      led        = 1'b1;
      errors     = 0;
    endfunction

    // data bytes that follow a status byte which opens a message
    static function int unsigned data_bytes(input logic [7:0] s);
      if (s[7:4] == mbsp_pkg::HI_PROG || s[7:4] == mbsp_pkg::HI_CHAN_AT) return 1;
      if (s == mbsp_pkg::BYTE_QFRAME || s == mbsp_pkg::BYTE_SONGSEL ||
          s == mbsp_pkg::BYTE_F9) return 1;
      return 2;
    endfunction

    // held data bytes are left alone, only a report clears them
    function void open_msg(input logic [PW-1:0] p, input logic [7:0] s,
                           input logic [1:0] len);
      status_held[p] = s;
      seen[p]        = 2'd1;
      expected[p]    = len;
    endfunction

    // an accepted request: work out the result it owes
    function void take_byte(input logic [PW-1:0] p, input logic [7:0] b);
      msg_t       m;
      logic [1:0] cnt;
      logic [7:0] s;
      m = '0;
      if (b[7]) begin
        if (b[7:4] != mbsp_pkg::HI_SYSTEM) begin
          open_msg(p, b, (b[7:4] == mbsp_pkg::HI_PROG || b[7:4] == mbsp_pkg::HI_CHAN_AT) ?
                         mbsp_pkg::LEN_SHORT : mbsp_pkg::LEN_LONG);
        end else begin
          case (b)
            mbsp_pkg::BYTE_SYSEX, mbsp_pkg::BYTE_SONGPTR:
              open_msg(p, b, mbsp_pkg::LEN_LONG);
            mbsp_pkg::BYTE_QFRAME, mbsp_pkg::BYTE_SONGSEL, mbsp_pkg::BYTE_F9:
              open_msg(p, b, mbsp_pkg::LEN_SHORT);
            mbsp_pkg::BYTE_F6:    m.kind = mbsp_pkg::KIND_F6;
            mbsp_pkg::BYTE_F7:    m.kind = mbsp_pkg::KIND_F7;
            mbsp_pkg::BYTE_CLOCK: begin
              m.kind = mbsp_pkg::KIND_CLOCK;
              if (beat_count == 0) led = 1'b1;
              else if (beat_count == mbsp_pkg::LED_OFF_COUNT) led = 1'b0;
              beat_count = (beat_count + 1) & 5'h1F;
              if (beat_count >= BEAT_LEN) beat_count = 0;
            end
            mbsp_pkg::BYTE_START: begin
              m.kind     = mbsp_pkg::KIND_START;
              beat_count = 0;
            end
            mbsp_pkg::BYTE_CONT:  m.kind = mbsp_pkg::KIND_CONT;
            mbsp_pkg::BYTE_STOP:  m.kind = mbsp_pkg::KIND_STOP;
            mbsp_pkg::BYTE_SENSE: m.kind = mbsp_pkg::KIND_SENSE;
            mbsp_pkg::BYTE_RESET: m.kind = mbsp_pkg::KIND_RESET;
            default:              m.kind = mbsp_pkg::KIND_NONE;
          endcase
        end
      end else if (seen[p] != 2'd0) begin
        cnt     = seen[p] + 2'd1;
        seen[p] = cnt;
        if (cnt == mbsp_pkg::LEN_SHORT) first_held[p] = b[6:0];
        else if (cnt == mbsp_pkg::LEN_LONG) second_held[p] = b[6:0];
        if (cnt >= expected[p]) begin
          s = status_held[p];
          if (s[7:4] != mbsp_pkg::HI_SYSTEM) begin
            m.kind = {1'b0, s[7:4]} - 5'd7;
            m.chan = s[3:0];
          end else begin
            case (s)
              mbsp_pkg::BYTE_SYSEX:   m.kind = mbsp_pkg::KIND_SYSEX;
              mbsp_pkg::BYTE_QFRAME:  m.kind = mbsp_pkg::KIND_QFRAME;
              mbsp_pkg::BYTE_SONGPTR: m.kind = mbsp_pkg::KIND_SONGPTR;
              mbsp_pkg::BYTE_SONGSEL: m.kind = mbsp_pkg::KIND_SONGSEL;
              mbsp_pkg::BYTE_F9:      m.kind = mbsp_pkg::KIND_F9;
              default:                m.kind = mbsp_pkg::KIND_NONE;
            endcase
          end
          m.first        = first_held[p];
          m.second       = second_held[p];
          status_held[p] = '0;
          first_held[p]  = '0;
          second_held[p] = '0;
          seen[p]        = '0;
          expected[p]    = '0;
        end
      end
      m.msg_valid = (m.kind != mbsp_pkg::KIND_NONE);
      if (m.msg_valid) m.port = p;
      else m = '0;
      m.led = led;
      msgs_due.push_back(m);
    endfunction

    function void note_error();
      errors++;
      if (errors == REPORT_CAP) $display("%0t: further mismatch reports suppressed", $time);
    endfunction

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
        if (errors < REPORT_CAP)
          $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
        note_error();
      end
    endfunction

    // an accepted result: compare with the oldest owed one
    function void match_result(input msg_t got);
      msg_t want;
      if (msgs_due.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t: result with no request pending, expected none got kind %0d",
                   $time, got.kind);
        note_error();
        return;
      end
      want = msgs_due.pop_front();
      check_field("msg_valid",   32'(want.msg_valid), 32'(got.msg_valid));
      check_field("msg_kind",    32'(want.kind),      32'(got.kind));
      check_field("msg_port",    32'(want.port),      32'(got.port));
      check_field("channel",     32'(want.chan),      32'(got.chan));
      check_field("first_data",  32'(want.first),     32'(got.first));
      check_field("second_data", 32'(want.second),    32'(got.second));
      check_field("beat_led",    32'(want.led),       32'(got.led));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and the block
  // --------------------------------------------------------------------------
  logic          clk_i;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  logic [PW-1:0] port_i      = '0;
  logic [7:0]    rx_byte_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic          msg_valid_o;
  logic [4:0]    msg_kind_o;
  logic [PW-1:0] msg_port_o;
  logic [3:0]    channel_o;
  logic [6:0]    first_data_o;
  logic [6:0]    second_data_o;
  logic          beat_led_o;

  midi_byte_stream_parser_core #(
    .PORT_COUNT      (PORT_N),
    .CLOCKS_PER_BEAT (BEAT_LEN)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .port_i        (port_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .msg_valid_o   (msg_valid_o),
    .msg_kind_o    (msg_kind_o),
    .msg_port_o    (msg_port_o),
    .channel_o     (channel_o),
    .first_data_o  (first_data_o),
    .second_data_o (second_data_o),
    .beat_led_o    (beat_led_o)
  );

  midi_msg_book book = new();

  // both sides stop idling while this is set
  bit          steady = 1'b0;
  int unsigned bytes_sent;
  int unsigned cycles;

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stalls, every accepted result checked in order
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      book.match_result('{msg_valid_o, msg_kind_o, msg_port_o, channel_o,
                          first_data_o, second_data_o, beat_led_o});
    // stalls only start once reset is over
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (rst_ni) stall_left <= pick_gap();
    end
  end

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, book.msgs_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // one request, held until the block takes it
  task automatic send_byte(input logic [PW-1:0] p, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    port_i     <= p;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    book.take_byte(p, b);
    // undefined statuses are merely dropped, they do not count
    if (!(b inside {BYTE_UNDEF_F4, BYTE_UNDEF_F5, BYTE_UNDEF_FD})) bytes_sent++;
  endtask

  function automatic logic [7:0] rand_realtime();
    case ($urandom_range(0, 9))
      0:       return mbsp_pkg::BYTE_F6;
      1:       return mbsp_pkg::BYTE_F7;
      2:       return mbsp_pkg::BYTE_START;
      3:       return mbsp_pkg::BYTE_CONT;
      4:       return mbsp_pkg::BYTE_STOP;
      5:       return mbsp_pkg::BYTE_SENSE;
      6:       return mbsp_pkg::BYTE_RESET;
      default: return mbsp_pkg::BYTE_CLOCK;
    endcase
  endfunction

  // any status that opens a message, channel in the low nibble
  function automatic logic [7:0] rand_status();
    int unsigned r;
    r = $urandom_range(0, 11);
    case (r)
      7:       return mbsp_pkg::BYTE_SYSEX;
      8:       return mbsp_pkg::BYTE_QFRAME;
      9:       return mbsp_pkg::BYTE_SONGPTR;
      10:      return mbsp_pkg::BYTE_SONGSEL;
      11:      return mbsp_pkg::BYTE_F9;
      default: return {4'h8 + 4'(r), 4'($urandom_range(0, 15))};
    endcase
  endfunction

  // a status and some data bytes, real time bytes sprinkled in between
  task automatic send_msg(input logic [PW-1:0] p, input logic [7:0] s,
                          input int unsigned n_data);
    send_byte(p, s);
    repeat (n_data) begin
      if ($urandom_range(0, 6) == 0) send_byte(PW'($urandom_range(0, PORT_N - 1)), rand_realtime());
      send_byte(p, 8'($urandom_range(0, 127)));
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [PW-1:0] p;
    logic [7:0]    s;
    int unsigned   r;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    // note off with data extremes, then note on split by a clock on the other port
    send_byte(PW'(0), 8'h80); send_byte(PW'(0), 8'h00); send_byte(PW'(0), 8'h7F);
    send_byte(PW'(1), 8'h9F); send_byte(PW'(0), mbsp_pkg::BYTE_CLOCK);
    send_byte(PW'(1), 8'h7F); send_byte(PW'(1), 8'h55);
    // data with no status is dropped
    send_byte(PW'(0), 8'h05);
    // poly aftertouch, program change, channel aftertouch
    send_byte(PW'(1), 8'hA3); send_byte(PW'(1), 8'h01); send_byte(PW'(1), 8'h02);
    send_byte(PW'(0), 8'hCA); send_byte(PW'(0), 8'h40);
    send_byte(PW'(1), 8'hD0); send_byte(PW'(1), 8'h7F);
    // control change cut off by a pitch wheel, which then completes
    send_byte(PW'(0), 8'hB2); send_byte(PW'(0), 8'h10);
    send_byte(PW'(0), 8'hE7); send_byte(PW'(0), 8'h01); send_byte(PW'(0), 8'h02);
    // sysex: two data bytes reported, the third one dropped
    send_byte(PW'(1), mbsp_pkg::BYTE_SYSEX); send_byte(PW'(1), 8'h11);
    send_byte(PW'(1), 8'h22); send_byte(PW'(1), 8'h33);
    // undefined statuses give a result with no message
    send_byte(PW'(0), BYTE_UNDEF_F4); send_byte(PW'(1), BYTE_UNDEF_F5);
    send_byte(PW'(0), BYTE_UNDEF_FD);
    // short and long system messages, start resets the beat count
    send_byte(PW'(1), mbsp_pkg::BYTE_QFRAME); send_byte(PW'(1), 8'h60);
    send_byte(PW'(0), mbsp_pkg::BYTE_SONGPTR); send_byte(PW'(0), 8'h7F);
    send_byte(PW'(0), 8'h00);
    send_byte(PW'(1), mbsp_pkg::BYTE_SONGSEL); send_byte(PW'(1), 8'h3C);
    send_byte(PW'(0), mbsp_pkg::BYTE_F9); send_byte(PW'(0), 8'h7E);
    send_byte(PW'(1), mbsp_pkg::BYTE_START);

    // random part
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      // switch between idling and back to back stretches now and then
      if ($urandom_range(0, 39) == 0) steady = ($urandom_range(0, 2) == 0);
      p = PW'($urandom_range(0, PORT_N - 1));
      r = $urandom_range(0, 99);
      if (r < 55) begin
        s = rand_status();
        send_msg(p, s, midi_msg_book::data_bytes(s));
      end else if (r < 65) begin
        // truncated message, the next status on this port cuts it off
        s = rand_status();
        send_msg(p, s, $urandom_range(0, midi_msg_book::data_bytes(s) - 1));
      end else if (r < 70) begin
        // sysex, any data past its second data byte must be dropped
        send_msg(p, mbsp_pkg::BYTE_SYSEX, $urandom_range(2, 5));
      end else if (r < 80) begin
        send_byte(p, rand_realtime());
      end else if (r < 88) begin
        // clock runs of varying length, the long ones cross the led edges and the beat wrap
        repeat ($urandom_range(4, 30)) begin
          if ($urandom_range(0, 24) == 0) send_byte(p, mbsp_pkg::BYTE_START);
          else send_byte(PW'($urandom_range(0, PORT_N - 1)), mbsp_pkg::BYTE_CLOCK);
        end
      end else if (r < 95) begin
        send_byte(p, 8'($urandom_range(0, 127)));
      end else begin
        send_byte(p, 8'($urandom_range(0, 255)));
      end
    end
    in_valid_i <= 1'b0;

    // drain, then keep the clock running so that stray results can still show
    while (book.msgs_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
